// File: hdl/ure_pkg.sv
`timescale 1ns / 1ps

package ure_pkg;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_SETTLE    = 3'd1,
    PH_TRIGGER   = 3'd2,
    PH_WAIT_RISE = 3'd3,
    PH_MEASURE   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_RISE   = 2'd1,
    ST_NO_FALL   = 2'd2
  } status_t;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLES_PER_US  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_LIMIT     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_US     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_US      = 8'd3;

  localparam logic [7:0]  RST_CYCLES_PER_US  = 8'd72;
  localparam logic [31:0] RST_WAIT_LIMIT     = 32'd2160000;
  localparam logic [7:0]  RST_TRIGGER_US     = 8'd10;
  localparam logic [7:0]  RST_SETTLE_US      = 8'd2;

  localparam logic [31:0] CYCLE_MAX = 32'hFFFF_FFFF;
  localparam logic [15:0] MICRO_MAX = 16'hFFFF;

  // Distance = micro / 58 as a multiply by ceil(2^22 / 58); exact for 16-bit counts.
  localparam int          DIST_SHIFT = 22;
  localparam logic [16:0] DIST_RECIP = 17'd72316;
  localparam logic [10:0] DIST_MAX   = 11'd1023;

  typedef struct packed {
    logic [7:0]  cycles_per_us;
    logic [31:0] wait_limit;
    logic [7:0]  trigger_us;
    logic [7:0]  settle_us;
  } cfg_t;

endpackage

// File: hdl/ure_ifs.sv
`timescale 1ns / 1ps

interface ure_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo_level;
  modport source (output valid, output start_req, output echo_level, input ready);
  modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface

interface ure_out_if;
  logic       valid;
  logic       ready;
  logic       trigger_level;
  logic       busy_res;
  logic       done_res;
  logic [1:0] status;
  logic [9:0] distance_cm;
  modport source (output valid, output trigger_level, output busy_res, output done_res,
                  output status, output distance_cm, input ready);
  modport sink   (input valid, input trigger_level, input busy_res, input done_res,
                  input status, input distance_cm, output ready);
endinterface

interface ure_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/ure_cfg.sv
`timescale 1ns / 1ps

module ure_cfg (
  input  logic             clk,
  input  logic             rst_n,
  ure_cfg_if.sink          cfg_ch,
  output ure_pkg::cfg_t    cfg
);

  ure_pkg::cfg_t cfg_r;
  ure_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        ure_pkg::CFG_CYCLES_PER_US:  cfg_nxt.cycles_per_us  = cfg_ch.data[7:0];
        ure_pkg::CFG_WAIT_LIMIT:     cfg_nxt.wait_limit     = cfg_ch.data;
        ure_pkg::CFG_TRIGGER_US:     cfg_nxt.trigger_us     = cfg_ch.data[7:0];
        ure_pkg::CFG_SETTLE_US:      cfg_nxt.settle_us      = cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cycles_per_us  <= ure_pkg::RST_CYCLES_PER_US;
      cfg_r.wait_limit     <= ure_pkg::RST_WAIT_LIMIT;
      cfg_r.trigger_us     <= ure_pkg::RST_TRIGGER_US;
      cfg_r.settle_us      <= ure_pkg::RST_SETTLE_US;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: hdl/ure_dist.sv
`timescale 1ns / 1ps

module ure_dist (
  input  logic [15:0] micro,
  output logic [9:0]  distance
);

  logic [32:0] prod;
  logic [10:0] quot;

  assign prod = {17'd0, micro} * {16'd0, ure_pkg::DIST_RECIP};
  assign quot = prod[32:ure_pkg::DIST_SHIFT];
  assign distance = (quot > ure_pkg::DIST_MAX) ? ure_pkg::DIST_MAX[9:0] : quot[9:0];

endmodule

// File: hdl/ultrasonic_echo_ranger.sv
`timescale 1ns / 1ps
// The result for an item is registered and offered in the cycle after the item is taken.
// Throughput: one item per cycle; the measurement state machine advances once per accepted item
// and the output register takes a new item only when empty or while its result is taken.
// Reset (rst_n low, synchronous): idle phase, counters, last distance and status cleared,
// configuration back to the package reset values for clock ratio and timeout, 10 us trigger, 2 us settle.
module ultrasonic_echo_ranger (
  input  logic       clk,
  input  logic       rst_n,
  ure_in_if.sink     in_ch,
  ure_out_if.source  out_ch,
  ure_cfg_if.sink    cfg_ch
);

  ure_pkg::cfg_t   cfg;
  ure_pkg::phase_t phase_r, phase_nxt;
  logic [31:0]     cycle_count_r, cycle_count_nxt;
  logic [7:0]      prescale_r, prescale_nxt;
  logic [15:0]     micro_r, micro_nxt;
  logic [9:0]      last_distance_r, last_distance_nxt;
  ure_pkg::status_t last_status_r, last_status_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic            out_trigger_r, out_busy_r, out_done_r;
  logic            done_nxt;

  logic            in_acc;
  logic [7:0]      div;
  logic [7:0]      pre_inc;
  logic            wrap;
  logic [7:0]      pre_tick;
  logic [15:0]     micro_tick;
  logic [31:0]     cycle_tick;
  logic            timeout_tick;
  logic            timeout_first;
  logic            div_one;
  logic [9:0]      dist_q;

  ure_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  ure_dist u_dist (
    .micro    (micro_r),
    .distance (dist_q)
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // One tick of the cycle counter and the microsecond prescaler.
  assign div        = (cfg.cycles_per_us == 8'd0) ? 8'd1 : cfg.cycles_per_us;
  assign div_one    = (div == 8'd1);
  assign pre_inc    = prescale_r + 8'd1;
  assign wrap       = (pre_inc >= div);
  assign pre_tick   = wrap ? 8'd0 : pre_inc;
  assign micro_tick = (wrap && micro_r != ure_pkg::MICRO_MAX) ? micro_r + 16'd1 : micro_r;
  assign cycle_tick = (cycle_count_r != ure_pkg::CYCLE_MAX) ? cycle_count_r + 32'd1
                                                             : cycle_count_r;

  // The saturated count exceeds the limit exactly when the old count already reached it,
  // unless the limit is all ones.
  assign timeout_tick  = (cycle_count_r >= cfg.wait_limit) &&
                         (cfg.wait_limit != ure_pkg::CYCLE_MAX);
  assign timeout_first = (cfg.wait_limit == 32'd0);

  // Next state and counters.
  always_comb begin
    phase_nxt         = phase_r;
    cycle_count_nxt   = cycle_count_r;
    prescale_nxt      = prescale_r;
    micro_nxt         = micro_r;
    last_distance_nxt = last_distance_r;
    last_status_nxt   = last_status_r;
    unique case (phase_r) inside
      ure_pkg::PH_IDLE: begin
        if (in_ch.start_req) begin
          phase_nxt       = ure_pkg::PH_SETTLE;
          cycle_count_nxt = 32'd0;
          prescale_nxt    = 8'd0;
          micro_nxt       = 16'd0;
        end
      end
      ure_pkg::PH_SETTLE, ure_pkg::PH_TRIGGER: begin
        cycle_count_nxt = cycle_tick;
        prescale_nxt    = pre_tick;
        micro_nxt       = micro_tick;
        if (micro_tick >= {8'd0, (phase_r == ure_pkg::PH_SETTLE) ? cfg.settle_us
                                                                   : cfg.trigger_us}) begin
          phase_nxt       = (phase_r == ure_pkg::PH_SETTLE) ? ure_pkg::PH_TRIGGER
                                                             : ure_pkg::PH_WAIT_RISE;
          cycle_count_nxt = 32'd0;
          prescale_nxt    = 8'd0;
          micro_nxt       = 16'd0;
        end
      end
      ure_pkg::PH_WAIT_RISE: begin
        if (in_ch.echo_level) begin
          // The rise tick is the first high cycle, counted from cleared counters.
          phase_nxt       = ure_pkg::PH_MEASURE;
          cycle_count_nxt = 32'd1;
          prescale_nxt    = div_one ? 8'd0 : 8'd1;
          micro_nxt       = div_one ? 16'd1 : 16'd0;
          if (timeout_first) begin
            phase_nxt       = ure_pkg::PH_IDLE;
            last_status_nxt = ure_pkg::ST_NO_FALL;
          end
        end else begin
          cycle_count_nxt = cycle_tick;
          prescale_nxt    = pre_tick;
          micro_nxt       = micro_tick;
          if (timeout_tick) begin
            phase_nxt       = ure_pkg::PH_IDLE;
            last_status_nxt = ure_pkg::ST_NO_RISE;
          end
        end
      end
      ure_pkg::PH_MEASURE: begin
        if (!in_ch.echo_level) begin
          phase_nxt         = ure_pkg::PH_IDLE;
          last_distance_nxt = dist_q;
          last_status_nxt   = ure_pkg::ST_OK;
        end else begin
          cycle_count_nxt = cycle_tick;
          prescale_nxt    = pre_tick;
          micro_nxt       = micro_tick;
          if (timeout_tick) begin
            phase_nxt       = ure_pkg::PH_IDLE;
            last_status_nxt = ure_pkg::ST_NO_FALL;
          end
        end
      end
      default: phase_nxt = ure_pkg::PH_IDLE;
    endcase
  end

  // Result flags for this item.
  always_comb begin
    unique case (phase_r)
      ure_pkg::PH_WAIT_RISE: done_nxt = in_ch.echo_level ? timeout_first : timeout_tick;
      ure_pkg::PH_MEASURE:   done_nxt = !in_ch.echo_level || timeout_tick;
      default:               done_nxt = 1'b0;
    endcase
  end

  assign out_valid_nxt = in_acc || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= ure_pkg::PH_IDLE;
      cycle_count_r   <= 32'd0;
      prescale_r      <= 8'd0;
      micro_r         <= 16'd0;
      last_distance_r <= 10'd0;
      last_status_r   <= ure_pkg::ST_OK;
      out_valid_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        phase_r         <= phase_nxt;
        cycle_count_r   <= cycle_count_nxt;
        prescale_r      <= prescale_nxt;
        micro_r         <= micro_nxt;
        last_distance_r <= last_distance_nxt;
        last_status_r   <= last_status_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_trigger_r <= (phase_nxt == ure_pkg::PH_TRIGGER);
      out_busy_r    <= (phase_nxt != ure_pkg::PH_IDLE);
      out_done_r    <= done_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.trigger_level = out_trigger_r;
  assign out_ch.busy_res      = out_busy_r;
  assign out_ch.done_res      = out_done_r;
  assign out_ch.status        = last_status_r;
  assign out_ch.distance_cm   = last_distance_r;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready) else $error("input stalled with empty output register");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> !out_busy_r) else $error("done reported while busy");

  a_trigger_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_trigger_r |-> out_busy_r) else $error("trigger high while idle");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && phase_r == ure_pkg::PH_IDLE && !in_ch.start_req |=> phase_r == ure_pkg::PH_IDLE)
    else $error("left idle without a start request");

  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && done_nxt |=> phase_r == ure_pkg::PH_IDLE)
    else $error("measurement ended without returning to idle");

endmodule
